FILE: hdl/gca_pkg.sv
// Shared types and constants for the mixture component search block.
// Used by the front, the queue, the back end, the top level and the testbench.
`default_nettype none

package gca_pkg;

    // Operation codes carried from the front to the back end.
    typedef enum logic [3:0] {
        OP_MEAN  = 4'b0001,
        OP_COV   = 4'b0010,
        OP_FLAG  = 4'b0100,
        OP_PIXEL = 4'b1000
    } t_op;

    // Input kind codes.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Word select codes.
    localparam logic [3:0] SEL_MEAN_R    = 4'd0;
    localparam logic [3:0] SEL_MEAN_B    = 4'd2;
    localparam logic [3:0] SEL_COV_FIRST = 4'd3;
    localparam logic [3:0] SEL_COV_LAST  = 4'd11;
    localparam logic [3:0] SEL_FLAG      = 4'd12;

    // Register map.
    localparam int          APB_AW              = 3;
    localparam logic [0:0]  REG_COMPONENT_COUNT = 1'b0;

    // Datapath widths.
    localparam int D_W    = 18;  // pixel*256 - mean
    localparam int W_W    = 24;  // matrix word
    localparam int PROD_W = 42;  // matrix word times difference
    localparam int ROW_W  = 44;  // sum of three products
    localparam int QP_W   = 62;  // row times difference
    localparam int ACC_W  = 64;  // quadratic form

    localparam logic signed [ACC_W-1:0] DIST_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        t_op         op;
        logic [3:0]  comp;
        logic [3:0]  slot;
        logic [23:0] value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_item;

endpackage

`default_nettype wire

FILE: hdl/gca_if.sv
// Stream interfaces for the input words and the result words.
// Payload widths are fixed; no dependencies beyond valid/ready.
`default_nettype none

interface gca_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [3:0]         component_index;
    logic [3:0]         word_select;
    logic signed [23:0] load_value;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;

    modport source (output valid, kind, component_index, word_select, load_value,
                    pixel_red, pixel_green, pixel_blue, input ready);
    modport sink   (input valid, kind, component_index, word_select, load_value,
                    pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface gca_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         best_component;
    logic signed [62:0] best_distance;
    logic               none_active;

    modport source (output valid, best_component, best_distance, none_active,
                    input ready);
    modport sink   (input valid, best_component, best_distance, none_active,
                     output ready);
endinterface

`default_nettype wire

FILE: hdl/gca_front.sv
// Front end: accepts input words, decodes them into queue items, drops dead loads.
// Depends on gca_pkg and gca_in_if.
`default_nettype none

module gca_front #(
    parameter int MAX = 10
) (
    gca_in_if.sink         i_in,
    input  wire logic      i_push_ready,
    output logic           o_push_valid,
    output gca_pkg::t_item o_push_item
);

    logic       w_keep;
    gca_pkg::t_op w_op;
    logic [3:0] w_slot;
    logic       w_comp_ok;

    assign w_comp_ok = {1'b0, i_in.component_index} < 5'(MAX);

    always_comb begin
        w_op   = gca_pkg::OP_PIXEL;
        w_slot = i_in.word_select;
        w_keep = 1'b1;
        if (i_in.kind == gca_pkg::KIND_LOAD) begin
            unique case (i_in.word_select) inside
                [gca_pkg::SEL_MEAN_R:gca_pkg::SEL_MEAN_B]: begin
                    w_op = gca_pkg::OP_MEAN;
                end
                [gca_pkg::SEL_COV_FIRST:gca_pkg::SEL_COV_LAST]: begin
                    w_op   = gca_pkg::OP_COV;
                    w_slot = i_in.word_select - gca_pkg::SEL_COV_FIRST;
                end
                gca_pkg::SEL_FLAG: begin
                    w_op = gca_pkg::OP_FLAG;
                end
                default: begin
                    w_keep = 1'b0;
                end
            endcase
            if (!w_comp_ok) begin
                w_keep = 1'b0;
            end
        end
    end

    // Dropped loads are taken whenever the queue could take a word.
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid && w_keep;

    assign o_push_item.op    = w_op;
    assign o_push_item.comp  = i_in.component_index;
    assign o_push_item.slot  = w_slot;
    assign o_push_item.value = i_in.load_value;
    assign o_push_item.red   = i_in.pixel_red;
    assign o_push_item.green = i_in.pixel_green;
    assign o_push_item.blue  = i_in.pixel_blue;

endmodule

`default_nettype wire

FILE: hdl/gca_queue.sv
// Short FIFO of decoded items between the front end and the back end.
// Depends on gca_pkg.
`default_nettype none

module gca_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    input  wire gca_pkg::t_item i_push_item,
    output logic                o_push_ready,
    output logic                o_pop_valid,
    output gca_pkg::t_item      o_pop_item,
    input  wire logic           i_pop_ready
);

    localparam int PW = $clog2(gca_pkg::QUEUE_DEPTH);
    localparam int CW = PW + 1;

    gca_pkg::t_item r_mem [gca_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = r_cnt != CW'(gca_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_item   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gca_back.sv
// Back end: component table, quadratic form pipeline and minimum search.
// Depends on gca_pkg and gca_out_if.
`default_nettype none

module gca_back #(
    parameter int MAX = 10
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic [3:0] i_count,
    input  wire logic      i_pop_valid,
    input  wire gca_pkg::t_item i_pop_item,
    output logic           o_pop_ready,
    gca_out_if.source      o_out
);

    localparam int KW = (MAX > 1) ? $clog2(MAX) : 1;
    localparam int NS = 6;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;
    logic [4:0]  r_k, n_k;
    logic [4:0]  w_eff;
    logic        w_issue, w_start, w_zero;
    logic        w_we_mean, w_we_cov, w_we_flag;

    // component table
    logic [15:0]            r_mean_mem [3][MAX];
    logic [gca_pkg::W_W-1:0] r_cov_mem [9][MAX];
    logic [MAX-1:0]         r_active;

    logic [7:0] r_pix [3];

    // pipeline
    logic [NS:1] r_v, r_last;
    logic [15:0]                      r_mean1 [3];
    logic signed [gca_pkg::W_W-1:0]   r_cov1 [9];
    logic signed [gca_pkg::W_W-1:0]   r_cov2 [9];
    logic signed [gca_pkg::D_W-1:0]   r_d2 [3];
    logic signed [gca_pkg::D_W-1:0]   r_d3 [3];
    logic signed [gca_pkg::D_W-1:0]   r_d4 [3];
    logic signed [gca_pkg::PROD_W-1:0] r_prod3 [9];
    logic signed [gca_pkg::ROW_W-1:0] r_row4 [3];
    logic signed [gca_pkg::QP_W-1:0]  r_qp5 [3];
    logic signed [gca_pkg::ACC_W-1:0] r_acc6;
    logic [NS:1] r_act;
    logic [3:0]  r_kk [NS:1];

    // search result
    logic                             r_found;
    logic signed [gca_pkg::ACC_W-1:0] r_best;
    logic [3:0]                       r_best_k;
    logic                             w_upd;
    logic                             w_found;
    logic signed [gca_pkg::ACC_W-1:0] w_best;
    logic [3:0]                       w_best_k;

    logic                             r_out_valid;
    logic [3:0]                       r_out_k;
    logic signed [62:0]               r_out_dist;
    logic                             r_out_none;

    assign w_eff = ({1'b0, i_count} > 5'(MAX)) ? 5'(MAX) : {1'b0, i_count};

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        o_pop_ready = 1'b0;
        w_issue     = 1'b0;
        w_start     = 1'b0;
        w_zero      = 1'b0;
        w_we_mean   = 1'b0;
        w_we_cov    = 1'b0;
        w_we_flag   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    if (i_pop_item.op == gca_pkg::OP_PIXEL) begin
                        // hold the pixel until the result register is free
                        if (!r_out_valid) begin
                            o_pop_ready = 1'b1;
                            w_start     = 1'b1;
                            if (w_eff == '0) begin
                                w_zero = 1'b1;
                            end else begin
                                n_state = ST_ISSUE;
                                n_k     = '0;
                            end
                        end
                    end else begin
                        o_pop_ready = 1'b1;
                        w_we_mean   = i_pop_item.op == gca_pkg::OP_MEAN;
                        w_we_cov    = i_pop_item.op == gca_pkg::OP_COV;
                        w_we_flag   = i_pop_item.op == gca_pkg::OP_FLAG;
                    end
                end
            end
            ST_ISSUE: begin
                w_issue = 1'b1;
                n_k     = r_k + 1'b1;
                if (r_k == w_eff - 1'b1) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_v[NS] && r_last[NS]) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // table writes and reads
    always_ff @(posedge i_clk) begin
        if (w_we_mean) begin
            r_mean_mem[i_pop_item.slot[1:0]][i_pop_item.comp[KW-1:0]] <=
                i_pop_item.value[15:0];
        end
        if (w_we_cov) begin
            r_cov_mem[i_pop_item.slot][i_pop_item.comp[KW-1:0]] <= i_pop_item.value;
        end
        for (int j = 0; j < 3; j++) begin
            r_mean1[j] <= r_mean_mem[j][r_k[KW-1:0]];
        end
        for (int n = 0; n < 9; n++) begin
            r_cov1[n] <= r_cov_mem[n][r_k[KW-1:0]];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pix[0] <= i_pop_item.red;
            r_pix[1] <= i_pop_item.green;
            r_pix[2] <= i_pop_item.blue;
        end
        r_act[1] <= r_active[r_k[KW-1:0]];
        r_kk[1]  <= r_k[3:0];
        for (int s = 2; s <= NS; s++) begin
            r_act[s] <= r_act[s-1];
            r_kk[s]  <= r_kk[s-1];
        end
        for (int j = 0; j < 3; j++) begin
            r_d2[j] <= $signed({2'b00, r_pix[j], 8'h00}) - $signed({2'b00, r_mean1[j]});
            r_d3[j] <= r_d2[j];
            r_d4[j] <= r_d3[j];
        end
        for (int n = 0; n < 9; n++) begin
            r_cov2[n]  <= r_cov1[n];
            r_prod3[n] <= gca_pkg::PROD_W'(r_cov2[n] * r_d2[n % 3]);
        end
        for (int i = 0; i < 3; i++) begin
            r_row4[i] <= gca_pkg::ROW_W'(r_prod3[3*i]) + gca_pkg::ROW_W'(r_prod3[3*i+1])
                       + gca_pkg::ROW_W'(r_prod3[3*i+2]);
            r_qp5[i]  <= gca_pkg::QP_W'(r_row4[i] * r_d4[i]);
        end
        r_acc6 <= gca_pkg::ACC_W'(r_qp5[0]) + gca_pkg::ACC_W'(r_qp5[1])
                + gca_pkg::ACC_W'(r_qp5[2]);
    end

    // strict minimum, lowest index wins ties
    assign w_upd    = r_v[NS] && r_act[NS] && (!r_found || (r_acc6 < r_best));
    assign w_found  = r_found || w_upd;
    assign w_best   = w_upd ? r_acc6 : r_best;
    assign w_best_k = w_upd ? r_kk[NS] : r_best_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_active    <= '0;
            r_v         <= '0;
            r_last      <= '0;
            r_found     <= 1'b0;
            r_best      <= gca_pkg::DIST_MAX;
            r_best_k    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (w_we_flag) r_active[i_pop_item.comp[KW-1:0]] <= i_pop_item.value[0];
            r_v    <= {r_v[NS-1:1], w_issue};
            r_last <= {r_last[NS-1:1], w_issue && (r_k == w_eff - 1'b1)};
            if (w_start) begin
                r_found  <= 1'b0;
                r_best   <= gca_pkg::DIST_MAX;
                r_best_k <= '0;
            end else begin
                r_found  <= w_found;
                r_best   <= w_best;
                r_best_k <= w_best_k;
            end
            if (w_zero || (r_v[NS] && r_last[NS])) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_zero) begin
            r_out_k    <= '0;
            r_out_dist <= gca_pkg::DIST_MAX[62:0];
            r_out_none <= 1'b1;
        end else if (r_v[NS] && r_last[NS]) begin
            r_out_k    <= w_best_k;
            r_out_dist <= w_best[62:0];
            r_out_none <= !w_found;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.best_component = r_out_k;
    assign o_out.best_distance  = r_out_dist;
    assign o_out.none_active    = r_out_none;

endmodule

`default_nettype wire

FILE: hdl/gmm_component_assign.sv
// Top level: APB register, front end, item queue and search back end.
// Depends on gca_pkg, gca_if, gca_front, gca_queue and gca_back.
`default_nettype none

// Nearest colour mixture component by Mahalanobis form. Load words write one
// table word each. A pixel evaluates one component per cycle through a
// six-stage quadratic form pipeline, the first component_count components
// (at most MAX_COMPONENTS) in turn; when component_count is zero its result
// is registered without the pipeline. A four-entry queue keeps taking words
// while a pixel runs or its result waits. component_count sits at byte
// address 0.
module gmm_component_assign #(
    parameter int MAX_COMPONENTS = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gca_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    gca_in_if.sink                            i_in,
    gca_out_if.source                         o_out
);

    logic [3:0]     r_count;
    logic           w_reg0;
    logic           w_push_valid;
    logic           w_push_ready;
    gca_pkg::t_item w_push_item;
    logic           w_pop_valid;
    logic           w_pop_ready;
    gca_pkg::t_item w_pop_item;

    assign pready = 1'b1;
    assign w_reg0 = (paddr[gca_pkg::APB_AW-1:2] == gca_pkg::REG_COMPONENT_COUNT)
                  && (paddr[1:0] == 2'b00);
    assign prdata = w_reg0 ? {28'd0, r_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 4'd1;
        end else if (psel && penable && pwrite && pready && w_reg0) begin
            r_count <= pwdata[3:0];
        end
    end

    gca_front #(.MAX(MAX_COMPONENTS)) u_front (
        .i_in         (i_in),
        .i_push_ready (w_push_ready),
        .o_push_valid (w_push_valid),
        .o_push_item  (w_push_item)
    );

    gca_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item),
        .i_pop_ready  (w_pop_ready)
    );

    gca_back #(.MAX(MAX_COMPONENTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (r_count),
        .i_pop_valid (w_pop_valid),
        .i_pop_item  (w_pop_item),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: verif/gmm_component_assign_test.sv
// Self-checking testbench for gmm_component_assign: table loads, pixel search, register setup.
// Depends on gca_pkg and the gca_in_if / gca_out_if interfaces from the RTL.
`default_nettype none

module gmm_component_assign_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOMP = 10;
    localparam longint DIST_NONE = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [3:0]         comp;
        logic signed [62:0] distance;
        logic               none;
    } t_match;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [gca_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    gca_in_if  in_w ();
    gca_out_if out_w ();

    gmm_component_assign #(.MAX_COMPONENTS(NCOMP)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_w),
        .o_out   (out_w)
    );

    always #6 i_clk = ~i_clk;

    // predictor copy of the component table
    logic [15:0]        mean_tab [NCOMP][3];
    logic signed [23:0] cov_tab  [NCOMP][9];
    bit                 active_tab [NCOMP];
    int unsigned        search_count = 1;

    t_match match_q[$];
    int     errors = 0;
    int     pixels_sent = 0;
    int     loads_sent = 0;
    int     matches_seen = 0;
    bit     sender_gaps = 1'b1;
    bit     receiver_stalls = 1'b1;
    int     hold_request = 0;

    function automatic t_match nearest_component(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_match res;
        longint pix [3];
        longint d [3];
        longint row, acc, best;
        int     lim;
        bit     found;
        pix[0] = longint'(r);
        pix[1] = longint'(g);
        pix[2] = longint'(b);
        best = DIST_NONE;
        found = 1'b0;
        res.comp = '0;
        lim = (search_count > NCOMP) ? NCOMP : int'(search_count);
        for (int k = 0; k < lim; k++) begin
            if (!active_tab[k]) continue;
            for (int i = 0; i < 3; i++) d[i] = pix[i] * 256 - longint'(mean_tab[k][i]);
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                row = 0;
                for (int j = 0; j < 3; j++) row += longint'(cov_tab[k][i*3+j]) * d[j];
                acc += row * d[i];
            end
            if (!found || acc < best) begin
                best = acc;
                res.comp = k[3:0];
                found = 1'b1;
            end
        end
        res.distance = best[62:0];
        res.none = !found;
        return res;
    endfunction

    function automatic void apply_word(logic kind, logic [3:0] comp, logic [3:0] sel,
                                       logic [23:0] val, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
        if (kind == gca_pkg::KIND_PIXEL) begin
            match_q = {match_q, nearest_component(r, g, b)};
            pixels_sent++;
        end else begin
            loads_sent++;
            if (comp < NCOMP) begin
                if (sel < gca_pkg::SEL_COV_FIRST) mean_tab[comp][sel] = val[15:0];
                else if (sel <= gca_pkg::SEL_COV_LAST)
                    cov_tab[comp][sel - gca_pkg::SEL_COV_FIRST] = val;
                else if (sel == gca_pkg::SEL_FLAG) active_tab[comp] = val[0];
            end
        end
    endfunction

    // called at a rising edge; returns at the edge where the word is accepted
    task automatic send_word(logic kind, logic [3:0] comp, logic [3:0] sel, logic [23:0] val,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_w.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_w.valid           <= 1'b1;
        in_w.kind            <= kind;
        in_w.component_index <= comp;
        in_w.word_select     <= sel;
        in_w.load_value      <= val;
        in_w.pixel_red       <= r;
        in_w.pixel_green     <= g;
        in_w.pixel_blue      <= b;
        do @(posedge i_clk); while (!in_w.ready);
        apply_word(kind, comp, sel, val, r, g, b);
    endtask

    task automatic load_word(int comp, logic [3:0] sel, logic [23:0] val);
        send_word(gca_pkg::KIND_LOAD, comp[3:0], sel, val, 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic classify(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_word(gca_pkg::KIND_PIXEL, 4'($urandom), 4'($urandom), 24'($urandom), r, g, b);
    endtask

    // drop valid, let results drain, then cover trailing load words in the pipe
    task automatic wait_idle();
        in_w.valid <= 1'b0;
        while (match_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_count(logic [3:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gca_pkg::APB_AW'(4 * gca_pkg::REG_COMPONENT_COUNT);
        pwdata  <= {28'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        search_count = 32'(value);
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            classify(8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 65) begin
            load_word($urandom_range(0, NCOMP - 1), gca_pkg::SEL_FLAG,
                      {23'($urandom), 1'($urandom_range(0, 3) != 0)});
        end else if (pick < 73) begin
            // small positive diagonal weights keep distances comparable
            load_word($urandom_range(0, NCOMP - 1),
                      4'(gca_pkg::SEL_COV_FIRST + 4 * $urandom_range(0, 2)),
                      24'($urandom_range(0, 4095)));
        end else if (pick < 88) begin
            load_word($urandom_range(0, NCOMP - 1), 4'($urandom_range(0, gca_pkg::SEL_COV_LAST)),
                      24'($urandom));
        end else if (pick < 94) begin
            load_word($urandom_range(NCOMP, 15), 4'($urandom_range(0, 15)), 24'($urandom));
        end else begin
            load_word($urandom_range(0, 15), 4'($urandom_range(gca_pkg::SEL_FLAG + 1, 15)),
                      24'($urandom));
        end
    endtask

    task automatic test_table_setup();
        for (int k = 0; k < NCOMP; k++) begin
            for (int i = 0; i < 3; i++)
                load_word(k, 4'(gca_pkg::SEL_MEAN_R + i),
                          (k < 2) ? 24'h008000 : 24'($urandom_range(0, 65535)));
            for (int i = 0; i < 9; i++)
                load_word(k, 4'(gca_pkg::SEL_COV_FIRST + i),
                          (k < 2) ? ((i % 4 == 0) ? 24'd256 : 24'd0)
                                  : 24'($urandom_range(0, 2047)));
            load_word(k, gca_pkg::SEL_FLAG, 24'd1);
        end
    endtask

    task automatic test_directed();
        write_count(4'd2);
        classify(8'd128, 8'd128, 8'd128);  // two identical components: index 0 wins
        classify(8'd0, 8'd0, 8'd0);
        classify(8'd255, 8'd255, 8'd255);
        load_word(0, 4'(gca_pkg::SEL_COV_FIRST + 1), 24'h800000);  // most negative word
        load_word(0, gca_pkg::SEL_MEAN_B, 24'hFFFFFF);
        classify(8'd255, 8'd0, 8'd255);
        load_word(0, gca_pkg::SEL_COV_LAST, 24'h7FFFFF);
        classify(8'd0, 8'd255, 8'd0);
        load_word(15, gca_pkg::SEL_FLAG, 24'd0);  // out of range component
        load_word(0, 4'd13, 24'd0);      // unused select
        load_word(1, 4'd15, 24'hFFFFFF);
        classify(8'd17, 8'd200, 8'd90);
        load_word(0, gca_pkg::SEL_FLAG, 24'hFFFFFE);  // bit 0 clear: inactive
        load_word(1, gca_pkg::SEL_FLAG, 24'd0);
        classify(8'd10, 8'd20, 8'd30);       // none active
        load_word(1, gca_pkg::SEL_FLAG, 24'hFFFFFF);
        classify(8'd10, 8'd20, 8'd30);
        write_count(4'd0);
        classify(8'd1, 8'd2, 8'd3);          // nothing searched
        write_count(4'd15);
        classify(8'd99, 8'd0, 8'd255);
        write_count(4'd10);
        classify(8'd50, 8'd60, 8'd70);
    endtask

    task automatic test_random(logic [3:0] count, int n);
        write_count(count);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                sender_gaps = 1'b0;
                receiver_stalls = 1'b0;
            end
            if (i == 3 * n / 4) begin
                sender_gaps = 1'b1;
                receiver_stalls = 1'b1;
            end
            random_word();
        end
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        sender_gaps = 1'b0;
        for (int i = 0; i < 30; i++) classify(8'($urandom), 8'($urandom), 8'($urandom));
        sender_gaps = 1'b1;
        wait_idle();
        for (int i = 0; i < 10; i++) random_word();
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int     n;
        t_match want;
        out_w.ready <= 1'b0;
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
            end else begin
                n = receiver_stalls ? $urandom_range(0, 19) : 0;
            end
            if (n > 0) begin
                out_w.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_w.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_w.valid && i_rst_n));
            matches_seen++;
            if (match_q.size() == 0) begin
                $display("%0t: unexpected result word comp=%0d dist=%0d none=%0b", $time,
                         out_w.best_component, out_w.best_distance, out_w.none_active);
                errors++;
            end else begin
                want = match_q.pop_front();
                if (out_w.best_component !== want.comp) begin
                    $display("%0t: best_component expected %0d actual %0d", $time,
                             want.comp, out_w.best_component);
                    errors++;
                end
                if (out_w.best_distance !== want.distance) begin
                    $display("%0t: best_distance expected %0d actual %0d", $time,
                             want.distance, out_w.best_distance);
                    errors++;
                end
                if (out_w.none_active !== want.none) begin
                    $display("%0t: none_active expected %0b actual %0b", $time,
                             want.none, out_w.none_active);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int k = 0; k < NCOMP; k++) active_tab[k] = 1'b0;
        in_w.valid           <= 1'b0;
        in_w.kind            <= gca_pkg::KIND_LOAD;
        in_w.component_index <= '0;
        in_w.word_select     <= '0;
        in_w.load_value      <= '0;
        in_w.pixel_red       <= '0;
        in_w.pixel_green     <= '0;
        in_w.pixel_blue      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_setup();
        test_directed();
        test_backpressure();
        test_random(4'd1, 60);
        test_random(4'd10, 120);
        test_random(4'd15, 60);
        test_random(4'd0, 20);
        test_random(4'd5, 60);
        test_random(4'($urandom_range(1, 10)), 60);

        wait_idle();
        $display("Covered %0d pixel words and %0d load words, %0d results checked,",
                 pixels_sent, loads_sent, matches_seen);
        $display("component counts 0, 1, 5, 10 and 15, plus a long result hold-off.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
